// ===== hw/rtl/epr_pkg.sv =====
`timescale 1ns / 1ps

package epr_pkg;

  localparam int COUNT_BITS_DEF = 24;

  localparam int DIST_W  = 14;
  localparam int DIGIT_W = 4;
  localparam int ZONE_W  = 2;
  localparam int TICK_W  = 16;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 1;

  // result item bit offsets in out_tdata
  localparam int OFS_DIST  = 0;
  localparam int OFS_METRE = OFS_DIST + DIST_W;
  localparam int OFS_HUND  = OFS_METRE + DIGIT_W;
  localparam int OFS_TENS  = OFS_HUND + DIGIT_W;
  localparam int OFS_UNITS = OFS_TENS + DIGIT_W;
  localparam int OFS_ZONE  = OFS_UNITS + DIGIT_W;
  localparam int OFS_OVER  = OFS_ZONE + ZONE_W;

  localparam logic [DIST_W-1:0] MAX_MM         = 14'd9999;
  localparam logic [DIST_W-1:0] NEAR_RESET_MM  = 14'd1000;
  localparam logic [DIST_W-1:0] FAR_RESET_MM   = 14'd3000;

  // first tick count whose distance exceeds MAX_MM
  localparam logic [TICK_W-1:0] CLAMP_TICKS = 16'd58824;

  // floor(t*17/100) = (t * SCALE_MUL) >> SCALE_SHIFT, exact for t < CLAMP_TICKS
  localparam logic [24:0] SCALE_MUL   = 25'd22817026;
  localparam int          SCALE_SHIFT = 27;
  localparam int          SCALE_PROD_W = TICK_W + 25;

  // reciprocals, exact for distances below 10000
  localparam logic [14:0] DIV1000_MUL = 15'd16778;
  localparam int          DIV1000_SH  = 24;
  localparam logic [13:0] DIV100_MUL  = 14'd10486;
  localparam int          DIV100_SH   = 20;
  localparam logic [13:0] DIV10_MUL   = 14'd13108;
  localparam int          DIV10_SH    = 17;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAR  = 1'd1;

  localparam logic [ZONE_W-1:0] ZONE_NEAR = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_MID  = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_FAR  = 2'd2;

  typedef struct packed {
    logic [TICK_W-1:0] ticks;
    logic              sat;
    logic              clamp;
  } meas_t;

  typedef struct packed {
    logic [DIST_W-1:0] mm;
    logic              over;
  } dist_t;

endpackage

// ===== hw/rtl/epr_edge.sv =====
`timescale 1ns / 1ps

module epr_edge #(
  parameter int COUNT_BITS = epr_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          level,
  input  logic          down_ready,
  output logic          up_ready,
  output logic          meas_v,
  output epr_pkg::meas_t meas
);

  localparam logic [COUNT_BITS-1:0] TOP = {COUNT_BITS{1'b1}};

  logic                  last_r;
  logic                  armed_r;
  logic [COUNT_BITS-1:0] ticks_r;
  logic                  v_r;
  epr_pkg::meas_t        meas_r;

  logic rise, cont, fall;

  assign rise = level && !last_r;
  assign cont = level && last_r && armed_r;
  assign fall = !level && last_r && armed_r;

  assign up_ready = !v_r || down_ready;
  assign meas_v   = v_r;
  assign meas     = meas_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= 1'b0;
      armed_r <= 1'b0;
      ticks_r <= '0;
      v_r     <= 1'b0;
    end else begin
      if (accept) begin
        last_r <= level;
        if (rise) begin
          armed_r <= 1'b1;
          ticks_r <= COUNT_BITS'(1);
        end else if (cont) begin
          if (ticks_r != TOP) ticks_r <= ticks_r + COUNT_BITS'(1);
        end else if (fall) begin
          armed_r <= 1'b0;
        end
      end
      if (up_ready) v_r <= accept && fall;
    end
  end

  // capture the finished width; only the low bits matter below the clamp point
  always_ff @(posedge clk) begin
    if (up_ready && accept && fall) begin
      meas_r.ticks <= ticks_r[epr_pkg::TICK_W-1:0];
      meas_r.sat   <= (ticks_r == TOP);
      meas_r.clamp <= (ticks_r >= COUNT_BITS'(epr_pkg::CLAMP_TICKS));
    end
  end

endmodule

// ===== hw/rtl/epr_scale.sv =====
`timescale 1ns / 1ps

module epr_scale (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           meas_v,
  input  epr_pkg::meas_t meas,
  input  logic           down_ready,
  output logic           up_ready,
  output logic           dist_v,
  output epr_pkg::dist_t dist_mm
);

  logic                               v_r;
  epr_pkg::dist_t                     dist_r;
  logic [epr_pkg::SCALE_PROD_W-1:0]   prod;
  logic [epr_pkg::DIST_W-1:0]         d_raw;

  assign prod  = epr_pkg::SCALE_PROD_W'(meas.ticks)
               * epr_pkg::SCALE_PROD_W'(epr_pkg::SCALE_MUL);
  assign d_raw = prod[epr_pkg::SCALE_SHIFT +: epr_pkg::DIST_W];

  assign up_ready = !v_r || down_ready;
  assign dist_v   = v_r;
  assign dist_mm  = dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= meas_v;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && meas_v) begin
      dist_r.mm   <= meas.clamp ? epr_pkg::MAX_MM : d_raw;
      dist_r.over <= meas.clamp || meas.sat;
    end
  end

endmodule

// ===== hw/rtl/epr_digits.sv =====
`timescale 1ns / 1ps

module epr_digits (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              dist_v,
  input  epr_pkg::dist_t                    dist_mm,
  input  logic [epr_pkg::DIST_W-1:0]        near_mm,
  input  logic [epr_pkg::DIST_W-1:0]        far_mm,
  input  logic                              out_tready,
  output logic                              up_ready,
  output logic                              out_tvalid,
  output logic [epr_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  logic                                   v_r;
  logic [epr_pkg::OUT_TDATA_W-1:0]        data_r;

  logic [28:0] th_p;
  logic [27:0] h_p;
  logic [27:0] t_p;
  logic [3:0]  th;
  logic [6:0]  h_all;
  logic [9:0]  t_all;
  logic [6:0]  hund_w;
  logic [9:0]  tens_w;
  logic [13:0] units_w;
  logic [epr_pkg::ZONE_W-1:0] zone;

  // split into decimal digits by parallel reciprocal scaling
  assign th_p  = 29'(dist_mm.mm) * 29'(epr_pkg::DIV1000_MUL);
  assign h_p   = 28'(dist_mm.mm) * 28'(epr_pkg::DIV100_MUL);
  assign t_p   = 28'(dist_mm.mm) * 28'(epr_pkg::DIV10_MUL);
  assign th    = th_p[epr_pkg::DIV1000_SH +: 4];
  assign h_all = h_p[epr_pkg::DIV100_SH +: 7];
  assign t_all = t_p[epr_pkg::DIV10_SH +: 10];

  assign hund_w  = h_all - ({3'b0, th} * 7'd10);
  assign tens_w  = t_all - ({3'b0, h_all} * 10'd10);
  assign units_w = dist_mm.mm - ({4'b0, t_all} * 14'd10);

  always_comb begin
    if (dist_mm.mm <= near_mm)     zone = epr_pkg::ZONE_NEAR;
    else if (dist_mm.mm <= far_mm) zone = epr_pkg::ZONE_MID;
    else                           zone = epr_pkg::ZONE_FAR;
  end

  assign up_ready   = !v_r || out_tready;
  assign out_tvalid = v_r;
  assign out_tdata  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= dist_v;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && dist_v) begin
      data_r <= {7'b0, dist_mm.over, zone, units_w[3:0], tens_w[3:0], hund_w[3:0], th,
                 dist_mm.mm};
    end
  end

endmodule

// ===== hw/rtl/echo_pulse_range_meter.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Width  Contents
// in_      in   8      echo level sample, one per tick
// out_     out  40     distance, four digits, zone, over-range flag
// cfg_     in   14     near and far zone limits
//
// One input item per cycle while in_tready is high. A falling edge that ends a
// measurement yields its result through the stages edge/counter, scale multiply,
// and digit split with zone compare, in that order, each registered.
// Synchronous active-low reset clears the edge state and all stage valids and
// loads the limits with 1000 and 3000 mm.
// in_tready drops only when all three stages hold results and out_ is stalled.

module echo_pulse_range_meter #(
  parameter int COUNT_BITS = epr_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [epr_pkg::IN_TDATA_W-1:0]    in_tdata,   // [0] echo_level
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [13:0] distance_mm, [17:14] metre_digit, [21:18] hundreds_digit,
  // [25:22] tens_digit, [29:26] units_digit, [31:30] zone, [32] over_range
  output logic [epr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_we,
  input  logic [epr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [epr_pkg::DIST_W-1:0]        cfg_wdata
);

  logic [epr_pkg::DIST_W-1:0] near_r;
  logic [epr_pkg::DIST_W-1:0] far_r;

  logic           accept;
  logic           meas_v, scale_ready;
  epr_pkg::meas_t meas;
  logic           dist_v, digits_ready;
  epr_pkg::dist_t dist_mm;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= epr_pkg::NEAR_RESET_MM;
      far_r  <= epr_pkg::FAR_RESET_MM;
    end else if (cfg_we) begin
      case (cfg_index)
        epr_pkg::REG_NEAR: near_r <= cfg_wdata;
        epr_pkg::REG_FAR:  far_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  epr_edge #(.COUNT_BITS(COUNT_BITS)) u_edge (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .level      (in_tdata[0]),
    .down_ready (scale_ready),
    .up_ready   (in_tready),
    .meas_v     (meas_v),
    .meas       (meas)
  );

  epr_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .meas_v     (meas_v),
    .meas       (meas),
    .down_ready (digits_ready),
    .up_ready   (scale_ready),
    .dist_v     (dist_v),
    .dist_mm    (dist_mm)
  );

  epr_digits u_digits (
    .clk        (clk),
    .rst_n      (rst_n),
    .dist_v     (dist_v),
    .dist_mm    (dist_mm),
    .near_mm    (near_r),
    .far_mm     (far_r),
    .out_tready (out_tready),
    .up_ready   (digits_ready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  logic [13:0] o_dist;
  logic [3:0]  o_m, o_h, o_t, o_u;
  logic [1:0]  o_zone;

  assign o_dist = out_tdata[epr_pkg::OFS_DIST  +: epr_pkg::DIST_W];
  assign o_m    = out_tdata[epr_pkg::OFS_METRE +: epr_pkg::DIGIT_W];
  assign o_h    = out_tdata[epr_pkg::OFS_HUND  +: epr_pkg::DIGIT_W];
  assign o_t    = out_tdata[epr_pkg::OFS_TENS  +: epr_pkg::DIGIT_W];
  assign o_u    = out_tdata[epr_pkg::OFS_UNITS +: epr_pkg::DIGIT_W];
  assign o_zone = out_tdata[epr_pkg::OFS_ZONE  +: epr_pkg::ZONE_W];

  a_dist_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> o_dist <= epr_pkg::MAX_MM)
    else $error("distance above clamp");

  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (o_m < 4'd10) && (o_h < 4'd10) && (o_t < 4'd10) && (o_u < 4'd10) &&
      (({10'b0, o_m} * 14'd1000) + ({10'b0, o_h} * 14'd100) + ({10'b0, o_t} * 14'd10)
       + {10'b0, o_u} == o_dist))
    else $error("digits do not match distance");

  a_zone_near: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (o_dist <= near_r) |-> o_zone == epr_pkg::ZONE_NEAR)
    else $error("near zone missed");

  a_zone_far: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (o_dist > near_r) && (o_dist > far_r) |-> o_zone == epr_pkg::ZONE_FAR)
    else $error("far zone missed");

endmodule
